### rtl/playfair_cipher_encrypt_macros.svh
// ---------------------------------------------------------------------------
// playfair cipher encryptor assertion macros
// shared concurrent assertion forms used by the sequencer module
// ---------------------------------------------------------------------------
`ifndef PLAYFAIR_CIPHER_ENCRYPT_MACROS_SVH
`define PLAYFAIR_CIPHER_ENCRYPT_MACROS_SVH

// same-cycle implication
`define PFE_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define PFE_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

### rtl/pfe_pkg.sv
// ---------------------------------------------------------------------------
// playfair cipher encryptor package
// shared types, constants and small helpers
// ---------------------------------------------------------------------------
package pfe_pkg;

   localparam int GRID_SIDE = 5;
   localparam int CELLS     = GRID_SIDE * GRID_SIDE;
   localparam int ALPHA     = 26;
   localparam int COORD_W   = $clog2(GRID_SIDE);
   localparam int IDX_W     = $clog2(ALPHA);
   localparam int ADDR_W    = $clog2(CELLS);

   typedef logic [IDX_W-1:0]   letter_idx_type;
   typedef logic [COORD_W-1:0] coord_type;
   typedef logic [ADDR_W-1:0]  cell_addr_type;

   localparam letter_idx_type IDX_Q = letter_idx_type'(16);
   localparam letter_idx_type IDX_X = letter_idx_type'(23);
   localparam letter_idx_type IDX_LAST = letter_idx_type'(ALPHA - 1);

   localparam logic [7:0] ASCII_LOWER_A = 8'd97;
   localparam logic [7:0] ASCII_LOWER_Z = 8'd122;
   localparam logic [7:0] ASCII_UPPER_A = 8'd65;
   localparam logic [7:0] ASCII_UPPER_Z = 8'd90;
   localparam logic [7:0] CASE_GAP      = 8'd32;
   localparam logic [6:0] CHAR_BASE     = 7'd65;

   typedef enum logic [1:0] {
      REQ_KEY      = 2'd0,
      REQ_KEY_END  = 2'd1,
      REQ_TEXT     = 2'd2,
      REQ_TEXT_END = 2'd3
   } req_kind_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_PLACE,
      ST_FILL,
      ST_RD_A,
      ST_RD_B,
      ST_CALC,
      ST_RD_X,
      ST_EMIT_X,
      ST_RD_Y,
      ST_EMIT_Y,
      ST_EMIT_END
   } state_type;

   typedef struct packed {
      coord_type row;
      coord_type col;
   } pos_type;

   typedef struct packed {
      logic           place_en;
      letter_idx_type place_idx;
      logic           clear;
      logic           pos_rd_en;
      letter_idx_type pos_rd_addr;
      logic           sq_rd_en;
      cell_addr_type  sq_rd_addr;
   } store_cmd_type;

   typedef struct packed {
      logic           load;
      logic           has_char;
      letter_idx_type ch;
      logic           second;
      logic           msg_end;
   } emit_type;

   function automatic coord_type coord_inc(input coord_type c);
      coord_type r;
      r = (c == coord_type'(GRID_SIDE - 1)) ? '0 : c + 1'b1;
      return r;
   endfunction

   function automatic cell_addr_type cell_addr(input coord_type row, input coord_type col);
      cell_addr_type a;
      a = cell_addr_type'(row) * cell_addr_type'(GRID_SIDE) + cell_addr_type'(col);
      return a;
   endfunction

endpackage

### rtl/pfe_store.sv
// ---------------------------------------------------------------------------
// playfair cipher square store
// key square and letter position memories, used flags and fill counters
// ---------------------------------------------------------------------------
module pfe_store (
   input  logic                    clock,
   input  logic                    reset,
   input  pfe_pkg::store_cmd_type  cmd,
   output pfe_pkg::pos_type        pos_rd_data,
   output pfe_pkg::letter_idx_type sq_rd_data
);
   import pfe_pkg::*;

   letter_idx_type square_mem [CELLS];
   pos_type        pos_mem [ALPHA];

   logic [ALPHA-1:0] used_ff, used_in;
   cell_addr_type    fill_ff, fill_in;
   coord_type        row_ff, row_in;
   coord_type        col_ff, col_in;
   pos_type          pos_rd_ff;
   letter_idx_type   sq_rd_ff;
   logic             do_place;

   assign do_place = cmd.place_en && (cmd.place_idx != IDX_Q) && !used_ff[cmd.place_idx]
                     && (fill_ff < cell_addr_type'(CELLS));

   always_comb begin
      used_in = used_ff;
      fill_in = fill_ff;
      row_in  = row_ff;
      col_in  = col_ff;
      if (cmd.clear) begin
         used_in = '0;
         fill_in = '0;
         row_in  = '0;
         col_in  = '0;
      end else if (do_place) begin
         used_in[cmd.place_idx] = 1'b1;
         fill_in = fill_ff + 1'b1;
         if (col_ff == coord_type'(GRID_SIDE - 1)) begin
            col_in = '0;
            row_in = row_ff + 1'b1;
         end else begin
            col_in = col_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
         fill_ff <= '0;
         row_ff  <= '0;
         col_ff  <= '0;
      end else begin
         used_ff <= used_in;
         fill_ff <= fill_in;
         row_ff  <= row_in;
         col_ff  <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_place) begin
         square_mem[fill_ff]     <= cmd.place_idx;
         pos_mem[cmd.place_idx]  <= '{row: row_ff, col: col_ff};
      end
      if (cmd.pos_rd_en) begin
         pos_rd_ff <= pos_mem[cmd.pos_rd_addr];
      end
      if (cmd.sq_rd_en) begin
         sq_rd_ff <= square_mem[cmd.sq_rd_addr];
      end
   end

   assign pos_rd_data = pos_rd_ff;
   assign sq_rd_data  = sq_rd_ff;

endmodule

### rtl/pfe_ctrl.sv
// ---------------------------------------------------------------------------
// playfair cipher sequencer
// item decode, pending letter, digraph lookup steps and result emission
// ---------------------------------------------------------------------------
`include "playfair_cipher_encrypt_macros.svh"

module pfe_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   input  logic [1:0]              req_type,
   input  logic [7:0]              req_letter,
   output logic                    req_stall,
   input  logic                    out_free,
   output pfe_pkg::emit_type       emit,
   output pfe_pkg::store_cmd_type  cmd,
   input  pfe_pkg::pos_type        pos_rd_data,
   input  pfe_pkg::letter_idx_type sq_rd_data
);
   import pfe_pkg::*;

   state_type      state_ff, state_in;
   letter_idx_type pend_ff, pend_in;
   logic           pend_valid_ff, pend_valid_in;
   letter_idx_type scan_ff, scan_in;
   letter_idx_type idx_ff, idx_in;
   letter_idx_type a_ff, a_in;
   letter_idx_type b_ff, b_in;
   logic           end_ff, end_in;
   pos_type        pa_ff, pa_in;
   cell_addr_type  xaddr_ff, xaddr_in;
   cell_addr_type  yaddr_ff, yaddr_in;

   req_kind_type   kind;
   logic           req_xfer;
   logic [7:0]     key_fold;
   logic           key_ok;
   letter_idx_type key_idx;
   logic           text_ok;
   letter_idx_type text_idx;
   logic           same;
   coord_type      xr, xc, yr, yc;

   // item decode
   always_comb begin
      kind     = req_kind_type'(req_type);
      req_xfer = req_valid && !req_stall;
      key_fold = (req_letter >= ASCII_LOWER_A && req_letter <= ASCII_LOWER_Z)
                 ? req_letter - CASE_GAP : req_letter;
      key_ok   = (key_fold >= ASCII_UPPER_A) && (key_fold <= ASCII_UPPER_Z);
      key_idx  = letter_idx_type'(key_fold - ASCII_UPPER_A);
      text_idx = letter_idx_type'(req_letter - ASCII_LOWER_A);
      text_ok  = (req_letter >= ASCII_LOWER_A) && (req_letter <= ASCII_LOWER_Z)
                 && (text_idx != IDX_Q);
      same     = (text_idx == pend_ff);
   end

   // digraph rule on the two letter positions
   always_comb begin
      priority if (pa_ff.row == pos_rd_data.row) begin
         xr = pa_ff.row;
         xc = coord_inc(pa_ff.col);
         yr = pos_rd_data.row;
         yc = coord_inc(pos_rd_data.col);
      end else if (pa_ff.col == pos_rd_data.col) begin
         xr = coord_inc(pa_ff.row);
         xc = pa_ff.col;
         yr = coord_inc(pos_rd_data.row);
         yc = pos_rd_data.col;
      end else begin
         xr = pa_ff.row;
         xc = pos_rd_data.col;
         yr = pos_rd_data.row;
         yc = pa_ff.col;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_xfer) begin
               unique case (kind)
                  REQ_KEY:      state_in = key_ok ? ST_PLACE : ST_IDLE;
                  REQ_KEY_END:  state_in = ST_FILL;
                  REQ_TEXT:     state_in = (text_ok && pend_valid_ff) ? ST_RD_A : ST_IDLE;
                  REQ_TEXT_END: state_in = pend_valid_ff ? ST_RD_A : ST_EMIT_END;
               endcase
            end
         end
         ST_PLACE:    state_in = ST_IDLE;
         ST_FILL:     state_in = (scan_ff == IDX_LAST) ? ST_IDLE : ST_FILL;
         ST_RD_A:     state_in = ST_RD_B;
         ST_RD_B:     state_in = ST_CALC;
         ST_CALC:     state_in = ST_RD_X;
         ST_RD_X:     state_in = ST_EMIT_X;
         ST_EMIT_X:   state_in = out_free ? ST_RD_Y : ST_EMIT_X;
         ST_RD_Y:     state_in = ST_EMIT_Y;
         ST_EMIT_Y:   state_in = out_free ? ST_IDLE : ST_EMIT_Y;
         ST_EMIT_END: state_in = out_free ? ST_IDLE : ST_EMIT_END;
         default:     state_in = ST_IDLE;
      endcase
   end

   // outputs
   always_comb begin
      req_stall = (state_ff != ST_IDLE);
      cmd       = '0;
      emit      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            cmd.clear = req_xfer && (kind == REQ_TEXT_END);
         end
         ST_PLACE: begin
            cmd.place_en  = 1'b1;
            cmd.place_idx = idx_ff;
         end
         ST_FILL: begin
            cmd.place_en  = 1'b1;
            cmd.place_idx = scan_ff;
         end
         ST_RD_A: begin
            cmd.pos_rd_en   = 1'b1;
            cmd.pos_rd_addr = a_ff;
         end
         ST_RD_B: begin
            cmd.pos_rd_en   = 1'b1;
            cmd.pos_rd_addr = b_ff;
         end
         ST_CALC: begin
         end
         ST_RD_X: begin
            cmd.sq_rd_en   = 1'b1;
            cmd.sq_rd_addr = xaddr_ff;
         end
         ST_EMIT_X: begin
            emit.load     = out_free;
            emit.has_char = 1'b1;
            emit.ch       = sq_rd_data;
         end
         ST_RD_Y: begin
            cmd.sq_rd_en   = 1'b1;
            cmd.sq_rd_addr = yaddr_ff;
         end
         ST_EMIT_Y: begin
            emit.load     = out_free;
            emit.has_char = 1'b1;
            emit.ch       = sq_rd_data;
            emit.second   = 1'b1;
            emit.msg_end  = end_ff;
         end
         ST_EMIT_END: begin
            emit.load    = out_free;
            emit.msg_end = 1'b1;
         end
         default: begin
         end
      endcase
   end

   // working registers
   always_comb begin
      pend_in       = pend_ff;
      pend_valid_in = pend_valid_ff;
      scan_in       = scan_ff;
      idx_in        = idx_ff;
      a_in          = a_ff;
      b_in          = b_ff;
      end_in        = end_ff;
      pa_in         = pa_ff;
      xaddr_in      = xaddr_ff;
      yaddr_in      = yaddr_ff;
      if (state_ff == ST_IDLE && req_xfer) begin
         idx_in  = key_idx;
         scan_in = '0;
         unique case (kind)
            REQ_KEY, REQ_KEY_END: begin
            end
            REQ_TEXT: begin
               if (text_ok) begin
                  if (!pend_valid_ff) begin
                     pend_in       = text_idx;
                     pend_valid_in = 1'b1;
                  end else begin
                     a_in   = pend_ff;
                     b_in   = same ? IDX_X : text_idx;
                     end_in = 1'b0;
                     if (!same) begin
                        pend_in       = '0;
                        pend_valid_in = 1'b0;
                     end
                  end
               end
            end
            REQ_TEXT_END: begin
               a_in          = pend_ff;
               b_in          = IDX_X;
               end_in        = 1'b1;
               pend_in       = '0;
               pend_valid_in = 1'b0;
            end
         endcase
      end
      if (state_ff == ST_FILL) begin
         scan_in = scan_ff + 1'b1;
      end
      if (state_ff == ST_RD_B) begin
         pa_in = pos_rd_data;
      end
      if (state_ff == ST_CALC) begin
         xaddr_in = cell_addr(xr, xc);
         yaddr_in = cell_addr(yr, yc);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         pend_ff       <= '0;
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         pend_ff       <= pend_in;
         pend_valid_ff <= pend_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_ff  <= scan_in;
      idx_ff   <= idx_in;
      a_ff     <= a_in;
      b_ff     <= b_in;
      end_ff   <= end_in;
      pa_ff    <= pa_in;
      xaddr_ff <= xaddr_in;
      yaddr_ff <= yaddr_in;
   end

   `PFE_ASSERT_IMP(a_emit_free, clock, reset, emit.load, out_free, "result loaded while output busy")
   `PFE_ASSERT_IMP(a_end_last, clock, reset, emit.load && emit.msg_end, emit.second || !emit.has_char, "message end not on last result")
   `PFE_ASSERT_NEXT(a_end_clears, clock, reset, req_xfer && (kind == REQ_TEXT_END), !pend_valid_ff && (state_ff == ST_RD_A || state_ff == ST_EMIT_END), "text end did not flush")

endmodule

### rtl/playfair_cipher_encrypt.sv
// ---------------------------------------------------------------------------
// playfair cipher encryptor
// builds a 5x5 key square and enciphers lower-case text in digraphs
// ---------------------------------------------------------------------------
// req channel: req_type selects key letter, key end, text letter or text end;
//   req_letter is the raw byte. req_stall is high while an item is in work.
// rsp channel: at most one cipher letter per transfer, rsp_pair_second marks the
//   second letter of a digraph, rsp_message_end the last result of a text end.
// steps per item, with the output register free:
//   key letter: a place step; text letter without a partner: decode only;
//   key end: the fill walk, one alphabet letter per cycle;
//   digraph: two position reads, then two square reads through the
//   single read port of each memory, each square read followed by a result load;
//   text end with nothing pending: one message end load.
// a result waits in the output register while rsp_stall is high; the block
//   takes the next item meanwhile and holds only when it must load another.
// reset clears the sequencer, the pending letter, the used flags and the
//   fill count; the square is undefined until a key end completes it.
// ---------------------------------------------------------------------------
module playfair_cipher_encrypt (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [1:0] req_type,
   input  logic [7:0] req_letter,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [6:0] rsp_cipher_char,
   output logic       rsp_char_valid,
   output logic       rsp_pair_second,
   output logic       rsp_message_end
);
   import pfe_pkg::*;

   emit_type       emit;
   store_cmd_type  cmd;
   pos_type        pos_rd_data;
   letter_idx_type sq_rd_data;
   logic           out_free;

   logic           rsp_valid_ff, rsp_valid_in;
   logic [6:0]     char_ff, char_in;
   logic           char_valid_ff, char_valid_in;
   logic           second_ff, second_in;
   logic           end_ff, end_in;

   pfe_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_type    (req_type),
      .req_letter  (req_letter),
      .req_stall   (req_stall),
      .out_free    (out_free),
      .emit        (emit),
      .cmd         (cmd),
      .pos_rd_data (pos_rd_data),
      .sq_rd_data  (sq_rd_data)
   );

   pfe_store u_store (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .pos_rd_data (pos_rd_data),
      .sq_rd_data  (sq_rd_data)
   );

   // output register
   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_valid_in  = rsp_valid_ff;
      char_in       = char_ff;
      char_valid_in = char_valid_ff;
      second_in     = second_ff;
      end_in        = end_ff;
      if (emit.load) begin
         rsp_valid_in  = 1'b1;
         char_in       = emit.has_char ? CHAR_BASE + 7'(emit.ch) : 7'd0;
         char_valid_in = emit.has_char;
         second_in     = emit.second;
         end_in        = emit.msg_end;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      char_ff       <= char_in;
      char_valid_ff <= char_valid_in;
      second_ff     <= second_in;
      end_ff        <= end_in;
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cipher_char = char_ff;
   assign rsp_char_valid  = char_valid_ff;
   assign rsp_pair_second = second_ff;
   assign rsp_message_end = end_ff;

endmodule
